### src/hpcc_pkg.sv
// shared constants and types of the hit pair coincidence cut
package hpcc_pkg;

	// default field widths
	localparam int POS_BITS_DEF = 14;
	localparam int TOT_BITS_DEF = 18;

	// fixed field widths
	localparam int ANGLE_W = 16;
	localparam int LIM_W   = 13;
	localparam int AMIN_W  = 15;
	localparam int OUT_W   = 8;

	localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd36000;

	// register reset values
	localparam logic [LIM_W-1:0]  Z_LIMIT_RST   = 13'd2300;
	localparam logic [LIM_W-1:0]  LOR_LIMIT_RST = 13'd2500;
	localparam logic [AMIN_W-1:0] ANGLE_MIN_RST = 15'd0;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOR_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOT_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOT_MAX   = 3'd4;

	// reject reasons
	localparam int REASON_W = 3;
	localparam logic [REASON_W-1:0] REASON_NONE  = 3'd0;
	localparam logic [REASON_W-1:0] REASON_Z     = 3'd1;
	localparam logic [REASON_W-1:0] REASON_LOR   = 3'd2;
	localparam logic [REASON_W-1:0] REASON_ANGLE = 3'd3;
	localparam logic [REASON_W-1:0] REASON_TOT1  = 3'd4;
	localparam logic [REASON_W-1:0] REASON_TOT2  = 3'd5;

	// per stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

	// cut failures that travel beside the distance datapath
	typedef struct packed {
		logic z_fail;
		logic ang_fail;
		logic t1_fail;
		logic t2_fail;
	} flags_t;

endpackage

### src/hit_pair_coincidence_cut_top.sv
// top level of the hit pair coincidence cut: handshake, registers and stage control
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   one hit pair per item
// m_axis    out  m_axis_tvalid/m_axis_tready   accepted flag and reject reason
// cfg       in   cfg_we                        register index and write data
//
// one item per clock sustained while m_axis_tready stays high; an accepted item
// reaches the output register through the five register stages of the distance test
// (products, squares, split square, split limit product, compare and reason)
// every stage keeps a valid bit and takes a new item when it is empty or its
// successor takes its item, so a stall at the output fills bubbles before
// s_axis_tready falls and no item is lost or repeated
// reset clears the valid bits and loads the register reset values; no clearing pass
module hit_pair_coincidence_cut_top #(
	parameter int POS_BITS = hpcc_pkg::POS_BITS_DEF,
	parameter int TOT_BITS = hpcc_pkg::TOT_BITS_DEF,
	localparam int HIT_W  = 3*POS_BITS + hpcc_pkg::ANGLE_W + TOT_BITS,
	localparam int IN_W   = ((2*HIT_W + 7) / 8) * 8,
	localparam int CFG_W  = (TOT_BITS > hpcc_pkg::AMIN_W) ? TOT_BITS : hpcc_pkg::AMIN_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// first_x, first_y, first_z, first_angle, first_tot,
	// second_x, second_y, second_z, second_angle, second_tot, zero fill
	input  logic [IN_W-1:0]                    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// accepted, reject_reason, zero fill
	output logic [hpcc_pkg::OUT_W-1:0]         m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [hpcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]                   cfg_data
);
	import hpcc_pkg::*;

	localparam int CW    = 2*POS_BITS;
	localparam int LW    = 2*POS_BITS+1;
	localparam int SPL   = (LW+1)/2;
	localparam int LSQ_W = 2*LIM_W;

	// field offsets inside one hit
	localparam int OFF_X = 0;
	localparam int OFF_Y = POS_BITS;
	localparam int OFF_Z = 2*POS_BITS;
	localparam int OFF_A = 3*POS_BITS;
	localparam int OFF_T = 3*POS_BITS + ANGLE_W;

	// configuration registers
	logic [LIM_W-1:0]    z_limit_q, lor_limit_q;
	logic [AMIN_W-1:0]   angle_min_q;
	logic [TOT_BITS-1:0] tot_min_q, tot_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_limit_q   <= Z_LIMIT_RST;
			lor_limit_q <= LOR_LIMIT_RST;
			angle_min_q <= ANGLE_MIN_RST;
			tot_min_q   <= '0;
			tot_max_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_Z_LIMIT:   z_limit_q   <= cfg_data[LIM_W-1:0];
				REG_LOR_LIMIT: lor_limit_q <= cfg_data[LIM_W-1:0];
				REG_ANGLE_MIN: angle_min_q <= cfg_data[AMIN_W-1:0];
				REG_TOT_MIN:   tot_min_q   <= cfg_data[TOT_BITS-1:0];
				REG_TOT_MAX:   tot_max_q   <= cfg_data[TOT_BITS-1:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// unpack the hit pair
	logic signed [POS_BITS-1:0] first_x, first_y, first_z;
	logic signed [POS_BITS-1:0] second_x, second_y, second_z;
	logic [ANGLE_W-1:0]         first_angle, second_angle;
	logic [TOT_BITS-1:0]        first_tot, second_tot;

	assign first_x      = s_axis_tdata[OFF_X +: POS_BITS];
	assign first_y      = s_axis_tdata[OFF_Y +: POS_BITS];
	assign first_z      = s_axis_tdata[OFF_Z +: POS_BITS];
	assign first_angle  = s_axis_tdata[OFF_A +: ANGLE_W];
	assign first_tot    = s_axis_tdata[OFF_T +: TOT_BITS];
	assign second_x     = s_axis_tdata[HIT_W + OFF_X +: POS_BITS];
	assign second_y     = s_axis_tdata[HIT_W + OFF_Y +: POS_BITS];
	assign second_z     = s_axis_tdata[HIT_W + OFF_Z +: POS_BITS];
	assign second_angle = s_axis_tdata[HIT_W + OFF_A +: ANGLE_W];
	assign second_tot   = s_axis_tdata[HIT_W + OFF_T +: TOT_BITS];

	// stage control: valid bits and a ready chain from the output back
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic room1, room2, room3, room4, room5;
	adv_t adv;

	assign room5 = !valid_s5 || m_axis_tready;
	assign room4 = !valid_s4 || room5;
	assign room3 = !valid_s3 || room4;
	assign room2 = !valid_s2 || room3;
	assign room1 = !valid_s1 || room2;

	assign s_axis_tready = room1;

	// data registers load only when a real item moves in
	assign adv.s1 = room1 && s_axis_tvalid;
	assign adv.s2 = room2 && valid_s1;
	assign adv.s3 = room3 && valid_s2;
	assign adv.s4 = room4 && valid_s3;
	assign adv.s5 = room5 && valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (room1) valid_s1 <= s_axis_tvalid;
			if (room2) valid_s2 <= valid_s1;
			if (room3) valid_s3 <= valid_s2;
			if (room4) valid_s4 <= valid_s3;
			if (room5) valid_s5 <= valid_s4;
		end
	end

	// datapath
	logic signed [CW-1:0]       p1_s1, p2_s1;
	logic signed [POS_BITS:0]   dx_s1, dy_s1;
	logic [ANGLE_W-1:0]         a1_s1, a2_s1;
	logic [LSQ_W-1:0]           lsq_s1;
	flags_t                     flags_s1, flags_s4;
	logic [2*CW-1:0]            c2_s4;
	logic [LSQ_W+SPL-1:0]       rlo_s4;
	logic [LSQ_W+LW-SPL-1:0]    rhi_s4;
	logic                       accepted_s5;
	logic [REASON_W-1:0]        reason_s5;

	hpcc_front #(
		.POS_BITS (POS_BITS),
		.TOT_BITS (TOT_BITS)
	) u_front (
		.clk          (clk),
		.adv          (adv),
		.first_x      (first_x),
		.first_y      (first_y),
		.first_z      (first_z),
		.first_angle  (first_angle),
		.first_tot    (first_tot),
		.second_x     (second_x),
		.second_y     (second_y),
		.second_z     (second_z),
		.second_angle (second_angle),
		.second_tot   (second_tot),
		.z_limit      (z_limit_q),
		.lor_limit    (lor_limit_q),
		.tot_min      (tot_min_q),
		.tot_max      (tot_max_q),
		.p1_s1        (p1_s1),
		.p2_s1        (p2_s1),
		.dx_s1        (dx_s1),
		.dy_s1        (dy_s1),
		.a1_s1        (a1_s1),
		.a2_s1        (a2_s1),
		.lsq_s1       (lsq_s1),
		.flags_s1     (flags_s1)
	);

	hpcc_mid #(
		.POS_BITS (POS_BITS)
	) u_mid (
		.clk       (clk),
		.adv       (adv),
		.p1_s1     (p1_s1),
		.p2_s1     (p2_s1),
		.dx_s1     (dx_s1),
		.dy_s1     (dy_s1),
		.a1_s1     (a1_s1),
		.a2_s1     (a2_s1),
		.lsq_s1    (lsq_s1),
		.flags_s1  (flags_s1),
		.angle_min (angle_min_q),
		.c2_s4     (c2_s4),
		.rlo_s4    (rlo_s4),
		.rhi_s4    (rhi_s4),
		.flags_s4  (flags_s4)
	);

	hpcc_decide #(
		.POS_BITS (POS_BITS)
	) u_decide (
		.clk         (clk),
		.adv         (adv),
		.c2_s4       (c2_s4),
		.rlo_s4      (rlo_s4),
		.rhi_s4      (rhi_s4),
		.flags_s4    (flags_s4),
		.accepted_s5 (accepted_s5),
		.reason_s5   (reason_s5)
	);

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {{(OUT_W-REASON_W-1){1'b0}}, reason_s5, accepted_s5};

	// input side closes only when stage 1 holds an item
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	// a stalled, completely full pipeline must refuse new items
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && !m_axis_tready)
		|-> !s_axis_tready)
		else $error("new item taken while the pipeline is full and stalled");

	// reason is a known code and agrees with the pass flag
	a_reason_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((reason_s5 <= REASON_TOT2)
			&& (accepted_s5 == (reason_s5 == REASON_NONE))))
		else $error("reject reason out of range or inconsistent with accepted");

endmodule

### src/hpcc_front.sv
// stage 1: cross products, differences, angle reduction, z and tot checks
module hpcc_front #(
	parameter int POS_BITS = hpcc_pkg::POS_BITS_DEF,
	parameter int TOT_BITS = hpcc_pkg::TOT_BITS_DEF
) (
	input  logic                              clk,
	input  hpcc_pkg::adv_t                    adv,
	input  logic signed [POS_BITS-1:0]        first_x,
	input  logic signed [POS_BITS-1:0]        first_y,
	input  logic signed [POS_BITS-1:0]        first_z,
	input  logic [hpcc_pkg::ANGLE_W-1:0]      first_angle,
	input  logic [TOT_BITS-1:0]               first_tot,
	input  logic signed [POS_BITS-1:0]        second_x,
	input  logic signed [POS_BITS-1:0]        second_y,
	input  logic signed [POS_BITS-1:0]        second_z,
	input  logic [hpcc_pkg::ANGLE_W-1:0]      second_angle,
	input  logic [TOT_BITS-1:0]               second_tot,
	input  logic [hpcc_pkg::LIM_W-1:0]        z_limit,
	input  logic [hpcc_pkg::LIM_W-1:0]        lor_limit,
	input  logic [TOT_BITS-1:0]               tot_min,
	input  logic [TOT_BITS-1:0]               tot_max,
	output logic signed [2*POS_BITS-1:0]      p1_s1,
	output logic signed [2*POS_BITS-1:0]      p2_s1,
	output logic signed [POS_BITS:0]          dx_s1,
	output logic signed [POS_BITS:0]          dy_s1,
	output logic [hpcc_pkg::ANGLE_W-1:0]      a1_s1,
	output logic [hpcc_pkg::ANGLE_W-1:0]      a2_s1,
	output logic [2*hpcc_pkg::LIM_W-1:0]      lsq_s1,
	output hpcc_pkg::flags_t                  flags_s1
);
	import hpcc_pkg::*;

	localparam int ZW = (POS_BITS > LIM_W) ? POS_BITS : LIM_W;

	logic [POS_BITS-1:0] z1_mag, z2_mag;
	logic [ANGLE_W-1:0]  a1_red, a2_red;
	flags_t              flags;

	always_comb begin
		// negating the most negative value leaves its bit pattern, which reads right unsigned
		z1_mag = first_z[POS_BITS-1] ? $unsigned(-first_z) : $unsigned(first_z);
		z2_mag = second_z[POS_BITS-1] ? $unsigned(-second_z) : $unsigned(second_z);
		// a 16 bit angle is below two full turns, one subtract reduces it
		a1_red = (first_angle >= FULL_TURN) ? first_angle - FULL_TURN : first_angle;
		a2_red = (second_angle >= FULL_TURN) ? second_angle - FULL_TURN : second_angle;
		flags.z_fail   = !((ZW'(z1_mag) < ZW'(z_limit)) && (ZW'(z2_mag) < ZW'(z_limit)));
		flags.ang_fail = 1'b0;
		flags.t1_fail  = (first_tot < tot_min) || (first_tot > tot_max);
		flags.t2_fail  = (second_tot < tot_min) || (second_tot > tot_max);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			p1_s1    <= first_x * second_y;
			p2_s1    <= second_x * first_y;
			dx_s1    <= (POS_BITS+1)'(first_x) - (POS_BITS+1)'(second_x);
			dy_s1    <= (POS_BITS+1)'(first_y) - (POS_BITS+1)'(second_y);
			a1_s1    <= a1_red;
			a2_s1    <= a2_red;
			lsq_s1   <= lor_limit * lor_limit;
			flags_s1 <= flags;
		end
	end

endmodule

### src/hpcc_mid.sv
// stages 2 to 4: squares for the distance test and the angle separation check
module hpcc_mid #(
	parameter int POS_BITS = hpcc_pkg::POS_BITS_DEF,
	localparam int CW    = 2*POS_BITS,
	localparam int LW    = 2*POS_BITS+1,
	localparam int SPL   = (LW+1)/2,
	localparam int LSQ_W = 2*hpcc_pkg::LIM_W
) (
	input  logic                              clk,
	input  hpcc_pkg::adv_t                    adv,
	input  logic signed [CW-1:0]              p1_s1,
	input  logic signed [CW-1:0]              p2_s1,
	input  logic signed [POS_BITS:0]          dx_s1,
	input  logic signed [POS_BITS:0]          dy_s1,
	input  logic [hpcc_pkg::ANGLE_W-1:0]      a1_s1,
	input  logic [hpcc_pkg::ANGLE_W-1:0]      a2_s1,
	input  logic [LSQ_W-1:0]                  lsq_s1,
	input  hpcc_pkg::flags_t                  flags_s1,
	input  logic [hpcc_pkg::AMIN_W-1:0]       angle_min,
	output logic [2*CW-1:0]                   c2_s4,
	output logic [LSQ_W+SPL-1:0]              rlo_s4,
	output logic [LSQ_W+LW-SPL-1:0]           rhi_s4,
	output hpcc_pkg::flags_t                  flags_s4
);
	import hpcc_pkg::*;

	// stage 2
	logic signed [CW:0]       xprod;
	logic [CW-1:0]            cmag;
	logic signed [CW+1:0]     dxsq, dysq;
	logic [ANGLE_W-1:0]       d;
	logic [CW-1:0]            cmag_s2, dx2_s2, dy2_s2;
	logic [ANGLE_W-1:0]       d_s2;
	logic [LSQ_W-1:0]         lsq_s2;
	flags_t                   flags_s2;

	// stage 3
	logic [ANGLE_W:0]         rest;
	flags_t                   flags_c3;
	logic [LW-1:0]            len2_s3;
	logic [CW-1:0]            chh_s3, chl_s3, cll_s3;
	logic [LSQ_W-1:0]         lsq_s3;
	flags_t                   flags_s3;

	always_comb begin
		xprod = (CW+1)'(p1_s1) - (CW+1)'(p2_s1);
		cmag  = xprod[CW] ? CW'($unsigned(-xprod)) : CW'($unsigned(xprod));
		dxsq  = dx_s1 * dx_s1;
		dysq  = dy_s1 * dy_s1;
		d     = (a1_s1 > a2_s1) ? a1_s1 - a2_s1 : a2_s1 - a1_s1;
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			cmag_s2  <= cmag;
			dx2_s2   <= CW'($unsigned(dxsq));
			dy2_s2   <= CW'($unsigned(dysq));
			d_s2     <= d;
			lsq_s2   <= lsq_s1;
			flags_s2 <= flags_s1;
		end
	end

	// separation is min(d, full turn - d); it fails if either side is below the minimum
	always_comb begin
		rest              = {1'b0, FULL_TURN} - {1'b0, d_s2};
		flags_c3          = flags_s2;
		flags_c3.ang_fail = (d_s2 < ANGLE_W'(angle_min)) || (rest < (ANGLE_W+1)'(angle_min));
	end

	// the cross magnitude is squared from its two halves
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			len2_s3  <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
			chh_s3   <= cmag_s2[CW-1:POS_BITS] * cmag_s2[CW-1:POS_BITS];
			chl_s3   <= cmag_s2[CW-1:POS_BITS] * cmag_s2[POS_BITS-1:0];
			cll_s3   <= cmag_s2[POS_BITS-1:0] * cmag_s2[POS_BITS-1:0];
			lsq_s3   <= lsq_s2;
			flags_s3 <= flags_c3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			c2_s4    <= {chh_s3, {CW{1'b0}}}
				+ {{(POS_BITS-1){1'b0}}, chl_s3, {(POS_BITS+1){1'b0}}}
				+ {{CW{1'b0}}, cll_s3};
			rlo_s4   <= lsq_s3 * len2_s3[SPL-1:0];
			rhi_s4   <= lsq_s3 * len2_s3[LW-1:SPL];
			flags_s4 <= flags_s3;
		end
	end

endmodule

### src/hpcc_decide.sv
// stage 5: distance compare and first failing cut
module hpcc_decide #(
	parameter int POS_BITS = hpcc_pkg::POS_BITS_DEF,
	localparam int CW    = 2*POS_BITS,
	localparam int LW    = 2*POS_BITS+1,
	localparam int SPL   = (LW+1)/2,
	localparam int LSQ_W = 2*hpcc_pkg::LIM_W
) (
	input  logic                              clk,
	input  hpcc_pkg::adv_t                    adv,
	input  logic [2*CW-1:0]                   c2_s4,
	input  logic [LSQ_W+SPL-1:0]              rlo_s4,
	input  logic [LSQ_W+LW-SPL-1:0]           rhi_s4,
	input  hpcc_pkg::flags_t                  flags_s4,
	output logic                              accepted_s5,
	output logic [hpcc_pkg::REASON_W-1:0]     reason_s5
);
	import hpcc_pkg::*;

	localparam int RW   = LSQ_W + LW;
	localparam int CMPW = (2*CW > RW) ? 2*CW : RW;

	logic [RW-1:0]       rhs;
	logic                lor_ok;
	logic [REASON_W-1:0] reason;

	always_comb begin
		rhs    = {rhi_s4, {SPL{1'b0}}} + RW'(rlo_s4);
		// coincident hits give 0 < 0 and fail here
		lor_ok = CMPW'(c2_s4) < CMPW'(rhs);
		if (flags_s4.z_fail)
			reason = REASON_Z;
		else if (!lor_ok)
			reason = REASON_LOR;
		else if (flags_s4.ang_fail)
			reason = REASON_ANGLE;
		else if (flags_s4.t1_fail)
			reason = REASON_TOT1;
		else if (flags_s4.t2_fail)
			reason = REASON_TOT2;
		else
			reason = REASON_NONE;
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			reason_s5   <= reason;
			accepted_s5 <= (reason == REASON_NONE);
		end
	end

endmodule
